// ===== rtl/mmtr_pkg.sv =====
`timescale 1ns / 1ps

package mmtr_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_GAP_THRESHOLD  = 2'd0,
    REG_BIT_THRESHOLD  = 2'd1,
    REG_FAST_THRESHOLD = 2'd2
  } cfg_reg_t;

  // Reset values of the configuration registers.
  localparam logic [15:0] GAP_THRESHOLD_RST  = 16'd510;
  localparam logic [15:0] BIT_THRESHOLD_RST  = 16'd56;
  localparam logic [16:0] FAST_THRESHOLD_RST = 17'd170;

  // Frame geometry.
  localparam logic [5:0] FRAME_EDGES = 6'd37;
  localparam logic [5:0] EDGE_MAX    = 6'd63;

  // Frame format codes.
  localparam logic [1:0] FMT_MM1  = 2'd0;
  localparam logic [1:0] FMT_MM2  = 2'd1;
  localparam logic [1:0] FMT_FAST = 2'd2;

  // Current configuration as seen by the deframer.
  typedef struct packed {
    logic [15:0] gap_threshold;
    logic [15:0] bit_threshold;
    logic [16:0] fast_pair_threshold;
  } cfg_t;

  // One decoded frame.
  typedef struct packed {
    logic [7:0] address_bits;
    logic [1:0] function_bits;
    logic [3:0] data_bits;
    logic [3:0] extra_bits;
    logic       fast_rate;
    logic [1:0] frame_format;
    logic       is_repeat;
  } frame_t;

endpackage

// ===== rtl/mmtr_cfg_regs.sv =====
`timescale 1ns / 1ps

module mmtr_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [31:0]     cfg_data,
  output mmtr_pkg::cfg_t  cfg
);
  import mmtr_pkg::*;

  // Writes are always taken; cfg_ready is tied high.
  assign cfg_ready = 1'b1;

  // Register file; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gap_threshold       <= GAP_THRESHOLD_RST;
      cfg.bit_threshold       <= BIT_THRESHOLD_RST;
      cfg.fast_pair_threshold <= FAST_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_GAP_THRESHOLD:  cfg.gap_threshold       <= cfg_data[15:0];
        REG_BIT_THRESHOLD:  cfg.bit_threshold       <= cfg_data[15:0];
        REG_FAST_THRESHOLD: cfg.fast_pair_threshold <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/mmtr_deframer.sv =====
`timescale 1ns / 1ps

module mmtr_deframer (
  input  logic             clk,
  input  logic             rst,
  input  mmtr_pkg::cfg_t   cfg,
  input  logic             pulse_valid,
  output logic             pulse_stall,
  input  logic [15:0]      pulse_length,
  input  logic             out_free,
  output logic             res_valid,
  output mmtr_pkg::frame_t res
);
  import mmtr_pkg::*;

  // Field region bounds (first and last sampled edges) and the rate-sampling edge.
  localparam logic [5:0] ADDR_LAST  = 6'd17;
  localparam logic [5:0] FUNC_LAST  = 6'd21;
  localparam logic [5:0] ADDR_FIRST = 6'd3;
  localparam logic [5:0] FUNC_FIRST = 6'd19;
  localparam logic [5:0] DATA_FIRST = 6'd23;
  localparam logic [5:0] XTRA_FIRST = 6'd25;
  localparam logic [5:0] RATE_EDGE  = 6'd3;

  // Input register.
  logic        in_valid;
  logic [15:0] pulse_q;
  logic        advance;

  // Frame state.
  logic [5:0]  edge_count;
  logic [15:0] prev_pulse;
  logic [7:0]  addr_acc;
  logic [1:0]  func_acc;
  logic [3:0]  data_acc;
  logic [3:0]  extra_acc;
  logic        rate_flag;
  logic [18:0] last_frame;
  logic        last_valid;

  logic [5:0]  edge_count_next;
  logic [7:0]  addr_acc_next;
  logic [1:0]  func_acc_next;
  logic [3:0]  data_acc_next;
  logic [3:0]  extra_acc_next;
  logic        rate_flag_next;

  logic        pause;
  logic        frame_done;
  logic        frame_bad;
  logic [5:0]  ec_base;
  logic [5:0]  ec_inc;
  logic [16:0] pair_sum;
  logic        sample_bit;
  logic [5:0]  off_addr;
  logic [5:0]  off_func;
  logic [5:0]  off_data;
  logic [5:0]  off_xtra;
  logic [18:0] packed_frame;
  logic        repeat_hit;

  // The input register moves whenever the output side can take a beat.
  assign advance     = in_valid && out_free;
  assign pulse_stall = in_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!pulse_stall) begin
      in_valid <= pulse_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!pulse_stall && pulse_valid) begin
      pulse_q <= pulse_length;
    end
  end

  // Pause detection, edge counting and bit sampling.
  always_comb begin
    pause      = pulse_q > cfg.gap_threshold;
    frame_done = pause && (edge_count == FRAME_EDGES);
    frame_bad  = pause && (edge_count != FRAME_EDGES) && (edge_count != 6'd0);
    ec_base    = pause ? 6'd1 : edge_count;
    ec_inc     = (ec_base == EDGE_MAX) ? ec_base : ec_base + 6'd1;
    pair_sum   = {1'b0, prev_pulse} + {1'b0, pulse_q};
    sample_bit = pulse_q > cfg.bit_threshold;
    off_addr   = ec_inc - ADDR_FIRST;
    off_func   = ec_inc - FUNC_FIRST;
    off_data   = ec_inc - DATA_FIRST;
    off_xtra   = ec_inc - XTRA_FIRST;

    addr_acc_next  = pause ? 8'd0 : addr_acc;
    func_acc_next  = pause ? 2'd0 : func_acc;
    data_acc_next  = pause ? 4'd0 : data_acc;
    extra_acc_next = pause ? 4'd0 : extra_acc;
    rate_flag_next = rate_flag;
    edge_count_next = (ec_base == 6'd0) ? 6'd0 : ec_inc;

    if (ec_base == RATE_EDGE) begin
      rate_flag_next = pair_sum < cfg.fast_pair_threshold;
    end

    // Each odd-numbered edge inside the frame carries one bit.
    if ((ec_base != 6'd0) && ec_inc[0] && (ec_inc <= FRAME_EDGES)) begin
      if (ec_inc <= ADDR_LAST) begin
        addr_acc_next[off_addr[3:1]] = addr_acc_next[off_addr[3:1]] | sample_bit;
      end else if (ec_inc <= FUNC_LAST) begin
        func_acc_next[off_func[1]] = func_acc_next[off_func[1]] | sample_bit;
      end else if (off_data[1:0] == 2'd0) begin
        data_acc_next[off_data[3:2]] = data_acc_next[off_data[3:2]] | sample_bit;
      end else begin
        extra_acc_next[off_xtra[3:2]] = extra_acc_next[off_xtra[3:2]] | sample_bit;
      end
    end
  end

  // Result of a completed frame, built from the fields before they clear.
  always_comb begin
    packed_frame = {rate_flag, extra_acc, data_acc, func_acc, addr_acc};
    repeat_hit   = last_valid && (last_frame == packed_frame);
    res.address_bits  = addr_acc;
    res.function_bits = func_acc;
    res.data_bits     = data_acc;
    res.extra_bits    = extra_acc;
    res.fast_rate     = rate_flag;
    res.is_repeat     = repeat_hit;
    if (rate_flag) begin
      res.frame_format = FMT_FAST;
    end else if (data_acc == extra_acc) begin
      res.frame_format = FMT_MM1;
    end else begin
      res.frame_format = FMT_MM2;
    end
  end

  assign res_valid = advance && frame_done;

  // State update, one beat per cycle while the output side is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count <= 6'd0;
      prev_pulse <= 16'd0;
      addr_acc   <= 8'd0;
      func_acc   <= 2'd0;
      data_acc   <= 4'd0;
      extra_acc  <= 4'd0;
      rate_flag  <= 1'b0;
      last_frame <= 19'd0;
      last_valid <= 1'b0;
    end else if (advance) begin
      edge_count <= edge_count_next;
      prev_pulse <= pulse_q;
      addr_acc   <= addr_acc_next;
      func_acc   <= func_acc_next;
      data_acc   <= data_acc_next;
      extra_acc  <= extra_acc_next;
      rate_flag  <= rate_flag_next;
      if (frame_done && !repeat_hit) begin
        last_frame <= packed_frame;
        last_valid <= 1'b1;
      end else if (frame_bad) begin
        last_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/mmtr_out_reg.sv =====
`timescale 1ns / 1ps

module mmtr_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  input  mmtr_pkg::frame_t res,
  output logic             out_free,
  output logic             frame_valid,
  input  logic             frame_stall,
  output mmtr_pkg::frame_t frame
);
  import mmtr_pkg::*;

  // The register can load when empty or when its beat leaves this cycle.
  assign out_free = !frame_valid || !frame_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (out_free) begin
      frame_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      frame <= res;
    end
  end

endmodule

// ===== rtl/mm_track_frame_receiver_core.sv =====
`timescale 1ns / 1ps

// Channel   Handshake                Payload
// pulse     pulse_valid/pulse_stall  pulse_length
// frame     frame_valid/frame_stall  address_bits .. is_repeat
// cfg       cfg_valid/cfg_ready      cfg_index, cfg_data
//
// One pulse beat is taken every cycle unless pulse_stall is high; a frame
// beat for the pause pulse that closes a full FRAME_EDGES frame passes the input
// register, then the result register. The deframer updates its state once
// per beat in a single combinational pass. Reset (rst, synchronous) loads
// default thresholds and clears all frame state. A stalled result holds the
// result register, and pulse_stall is then high while the input register is full.

module mm_track_frame_receiver_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        pulse_valid,
  output logic        pulse_stall,
  input  logic [15:0] pulse_length,
  output logic        frame_valid,
  input  logic        frame_stall,
  output logic [7:0]  address_bits,
  output logic [1:0]  function_bits,
  output logic [3:0]  data_bits,
  output logic [3:0]  extra_bits,
  output logic        fast_rate,
  output logic [1:0]  frame_format,
  output logic        is_repeat,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import mmtr_pkg::*;

  cfg_t   cfg;
  frame_t res;
  frame_t frame;
  logic   res_valid;
  logic   out_free;

  mmtr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mmtr_deframer u_deframer (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .pulse_valid  (pulse_valid),
    .pulse_stall  (pulse_stall),
    .pulse_length (pulse_length),
    .out_free     (out_free),
    .res_valid    (res_valid),
    .res          (res)
  );

  mmtr_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .res_valid   (res_valid),
    .res         (res),
    .out_free    (out_free),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame       (frame)
  );

  // Unpack the result register onto the payload ports.
  assign address_bits  = frame.address_bits;
  assign function_bits = frame.function_bits;
  assign data_bits     = frame.data_bits;
  assign extra_bits    = frame.extra_bits;
  assign fast_rate     = frame.fast_rate;
  assign frame_format  = frame.frame_format;
  assign is_repeat     = frame.is_repeat;

endmodule

// ===== rtl/mmtr_checker.sv =====
`timescale 1ns / 1ps

module mmtr_checker (
  input logic       clk,
  input logic       rst,
  input logic       pulse_stall,
  input logic       frame_valid,
  input logic       frame_stall,
  input logic [3:0] data_bits,
  input logic [3:0] extra_bits,
  input logic       fast_rate,
  input logic [1:0] frame_format
);
  import mmtr_pkg::*;

  // A stalled frame beat stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame_stall |=> frame_valid)
    else $error("frame beat dropped while stalled");

  // Reset empties both the input and the result register.
  a_reset: assert property (@(posedge clk)
    rst |=> !frame_valid && !pulse_stall)
    else $error("pipeline not empty after reset");

  // The double-rate class goes with the fast flag and nothing else.
  a_fast: assert property (@(posedge clk) disable iff (rst)
    frame_valid |-> (fast_rate == (frame_format == FMT_FAST)) &&
                    (frame_format == FMT_MM1 || frame_format == FMT_MM2 ||
                     frame_format == FMT_FAST))
    else $error("frame format disagrees with rate flag");

  // MM1 and MM2 follow from the data and extra nibbles.
  a_class: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !fast_rate |->
      ((frame_format == FMT_MM1) == (data_bits == extra_bits)))
    else $error("frame format disagrees with data nibbles");

endmodule

bind mm_track_frame_receiver_core mmtr_checker u_mmtr_checker (
  .clk          (clk),
  .rst          (rst),
  .pulse_stall  (pulse_stall),
  .frame_valid  (frame_valid),
  .frame_stall  (frame_stall),
  .data_bits    (data_bits),
  .extra_bits   (extra_bits),
  .fast_rate    (fast_rate),
  .frame_format (frame_format)
);
